@@ hw/rtl/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, register codes and channel arithmetic shared by the palette fade
// engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    // input item: load one entry or run a blend pass
    typedef struct packed {
        logic        kind;
        logic [4:0]  entry_index;
        logic [14:0] entry_color;
        logic [3:0]  blend_amount;
    } t_in_item;

    // result item: one blended palette entry
    typedef struct packed {
        logic [4:0]  out_index;
        logic [14:0] out_color;
        logic        last;
    } t_out_item;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_BLEND = 1'b1;

    // blend modes
    localparam logic MODE_TINT = 1'b0;
    localparam logic MODE_GRAY = 1'b1;

    // full blend strength in eighths
    localparam logic [3:0] K_FULL = 4'd8;

    // reciprocal of three, scaled by 2^9, exact for sums up to 93
    localparam logic [7:0] RECIP3 = 8'd171;

    // configuration port widths
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLEND_MODE   = 4'd0,
        CFG_TARGET_RED   = 4'd1,
        CFG_TARGET_GREEN = 4'd2,
        CFG_TARGET_BLUE  = 4'd3
    } t_cfg_reg;

    // rgb555 channels
    typedef struct packed {
        logic [4:0] blue;
        logic [4:0] green;
        logic [4:0] red;
    } t_rgb;

    // controls for a whole blend pass: amount is latched; user must hold mode and target steady, unenforced
    typedef struct packed {
        logic       mode;
        t_rgb       target;
        logic [3:0] amount;
    } t_blend_ctl;

    // one palette read travelling down the pipeline
    typedef struct packed {
        logic       valid;
        logic [4:0] index;
        logic       last;
    } t_beat;

    // sequencer states
    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_READ = 1'b1
    } t_seq_state;

    // luma: (r + g + b) / 3 by reciprocal multiply
    function automatic logic [4:0] luma3(input t_rgb c);
        logic [6:0]  sum;
        logic [14:0] prod;
        sum  = 7'(c.red) + 7'(c.green) + 7'(c.blue);
        prod = 15'(sum) * 15'(RECIP3);
        return prod[13:9];
    endfunction

    // c + floor((t - c) * k / 8), wrapped to five bits
    function automatic logic [4:0] mix_channel(input logic [4:0] c,
                                               input logic [4:0] t,
                                               input logic [3:0] k);
        logic signed [10:0] diff;
        logic signed [10:0] kext;
        logic signed [10:0] prod;
        logic signed [10:0] step;
        logic        [10:0] sum;
        diff = $signed(11'(t)) - $signed(11'(c));
        kext = $signed(11'(k));
        prod = diff * kext;
        step = prod >>> 3;
        sum  = 11'(c) + 11'(step);
        return sum[4:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pfe_blend.sv @@
// ----------------------------------------------------------------------------
// pfe_blend
// Two-stage blend datapath: luma stage, then per-channel mix into the
// output register with its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_blend (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pfe_pkg::t_beat     i_beat,
    input  wire logic [14:0]        i_color,
    input  wire pfe_pkg::t_blend_ctl i_ctl,
    output logic                    o_valid,
    output pfe_pkg::t_out_item      o_item
);
    import pfe_pkg::*;

    t_beat     r_beat_b;
    t_rgb      r_color_b;
    logic [4:0] r_luma_b;
    logic      r_valid_c;
    t_out_item r_item_c;

    t_rgb      w_target;
    t_out_item n_item_c;

    // luma stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_b.valid <= 1'b0;
        end else begin
            r_beat_b.valid <= i_beat.valid;
        end
        r_beat_b.index <= i_beat.index;
        r_beat_b.last  <= i_beat.last;
        r_color_b      <= t_rgb'(i_color);
        r_luma_b       <= luma3(t_rgb'(i_color));
    end

    // target select per mode
    always_comb begin
        if (i_ctl.mode == MODE_GRAY) begin
            w_target.red   = r_luma_b;
            w_target.green = r_luma_b;
            w_target.blue  = r_luma_b;
        end else begin
            w_target = i_ctl.target;
        end
    end

    // per-channel mix
    always_comb begin
        n_item_c.out_index = r_beat_b.index;
        n_item_c.last      = r_beat_b.last;
        n_item_c.out_color = {mix_channel(r_color_b.blue,  w_target.blue,  i_ctl.amount),
                              mix_channel(r_color_b.green, w_target.green, i_ctl.amount),
                              mix_channel(r_color_b.red,   w_target.red,   i_ctl.amount)};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
        end else begin
            r_valid_c <= r_beat_b.valid;
        end
        r_item_c <= n_item_c;
    end

    assign o_valid = r_valid_c;
    assign o_item  = r_item_c;

endmodule

`default_nettype wire

@@ hw/rtl/palette_fade_engine_top.sv @@
// ----------------------------------------------------------------------------
// palette_fade_engine_top
// RGB555 palette store with load items and blend passes toward a tint
// colour or toward each entry's own luma.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  input    | i_start, o_busy         | i_in  (t_in_item)
//  result   | o_out_valid (strobe)    | o_out (t_out_item)
//  config   | i_cfg_valid, o_cfg_ready| i_cfg_index, i_cfg_data
//
// A load item is written straight into the palette; busy stays low and the next
// item may follow at once. A blend pass reads one palette entry per cycle from
// the single memory read port and returns PALETTE_ENTRIES results through the
// read register and the two blend stages; busy stays high until the last result.
// Reset clears the sequencer, pipeline valids and the config registers; the
// palette itself has no reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_fade_engine_top #(
    parameter int PALETTE_ENTRIES = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire pfe_pkg::t_in_item                 i_in,
    output logic                                   o_busy,
    output logic                                   o_out_valid,
    output pfe_pkg::t_out_item                     o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pfe_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [pfe_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pfe_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [14:0]  mem [PALETTE_ENTRIES];

    t_seq_state   r_state;
    t_seq_state   n_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;
    logic         r_blend_mode;
    t_rgb         r_target;
    logic [3:0]   r_amount;
    t_beat        r_rd_beat;
    logic [14:0]  r_rd_data;

    logic         w_accept;
    logic         w_rd_en;
    logic         w_rd_last;
    logic         w_wr_en;
    t_blend_ctl   w_ctl;
    logic         w_pipe_busy;

    assign w_accept = i_start && !o_busy;
    assign w_wr_en  = w_accept && (i_in.kind == KIND_LOAD)
                      && (int'(i_in.entry_index) < PALETTE_ENTRIES);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SEQ_IDLE: begin
                if (w_accept && i_in.kind == KIND_BLEND) begin
                    n_state = SEQ_READ;
                end
            end
            SEQ_READ: begin
                if (w_rd_last) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_last = 1'b0;
        n_addr    = r_addr;
        unique case (r_state)
            SEQ_IDLE: begin
                n_addr = '0;
            end
            SEQ_READ: begin
                w_rd_en   = 1'b1;
                w_rd_last = (r_addr == AW'(PALETTE_ENTRIES - 1));
                n_addr    = r_addr + AW'(1);
            end
            default: n_addr = '0;
        endcase
    end

    // sequencer and pass controls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
        if (w_accept && i_in.kind == KIND_BLEND) begin
            r_amount <= (i_in.blend_amount > K_FULL) ? K_FULL : i_in.blend_amount;
        end
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[AW'(i_in.entry_index)] <= i_in.entry_color;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // read beat tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_beat.valid <= 1'b0;
        end else begin
            r_rd_beat.valid <= w_rd_en;
        end
        r_rd_beat.index <= 5'(r_addr);
        r_rd_beat.last  <= w_rd_last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= MODE_TINT;
            r_target     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLEND_MODE:   r_blend_mode   <= i_cfg_data[0];
                CFG_TARGET_RED:   r_target.red   <= i_cfg_data[4:0];
                CFG_TARGET_GREEN: r_target.green <= i_cfg_data[4:0];
                CFG_TARGET_BLUE:  r_target.blue  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign w_ctl.mode   = r_blend_mode;
    assign w_ctl.target = r_target;
    assign w_ctl.amount = r_amount;

    // blend datapath
    pfe_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (r_rd_beat),
        .i_color (r_rd_data),
        .i_ctl   (w_ctl),
        .o_valid (o_out_valid),
        .o_item  (o_out)
    );

    // busy while reading or while reads are still in the pipeline
    assign w_pipe_busy = r_rd_beat.valid || u_blend.r_beat_b.valid || o_out_valid;
    assign o_busy      = (r_state != SEQ_IDLE) || w_pipe_busy;

    // a blend pass delivers entry zero first, after the read register and both blend stages
    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.kind == KIND_BLEND)
        |-> ##4 (o_out_valid && o_out.out_index == 5'd0))
        else $error("blend pass did not start with entry zero");

    // results of a pass come back to back until the last one
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |=> o_out_valid)
        else $error("gap inside a blend pass");

    // the engine is free right after the last result
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last) |=> !o_busy)
        else $error("busy after final result");

    // no result outside a pass
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_busy)
        else $error("result strobe while idle");

endmodule

`default_nettype wire
